// ===== design/vgb_pkg.sv =====
// Shared types and constants of the vertical Gaussian blur.
// Pixel and row-info structs, register indexes, arithmetic widths.
// No dependencies; used by every module of the block.
`default_nettype none

package vgb_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int NUM_OFF    = 5;
    localparam int WC_W       = 17;
    localparam int WO_W       = 16;
    localparam int FW_W       = 12;
    localparam int FH_W       = 16;
    localparam int ROW_W      = 16;
    localparam int OCOL_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int FRAC_W     = 16;
    // pair sum (9 bit) times weight, and sum of up to six such products
    localparam int PROD_W     = 25;
    localparam int ACC_W      = 28;

    localparam logic [WC_W-1:0] WEIGHT_CENTER_RST = 17'd65536;
    localparam logic [WO_W-1:0] WEIGHT_OFF_RST    = 16'd0;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST  = 16'd480;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pix_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last_row;
        logic              last_col;
    } meta_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_CENTER,
        REG_WEIGHT_OFF1,
        REG_WEIGHT_OFF2,
        REG_WEIGHT_OFF3,
        REG_WEIGHT_OFF4,
        REG_WEIGHT_OFF5,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } reg_idx_t;

endpackage

`default_nettype wire

// ===== design/vgb_line_ram.sv =====
// One row bank of the line store: single write port, single registered read port.
// Read-first on a same-address collision. Uses vgb_pkg for the pixel type.
`default_nettype none

module vgb_line_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  wire                logic              clk,
    input  wire                logic              we,
    input  wire                logic [ADDR_W-1:0] waddr,
    input  wire                vgb_pkg::pix_t     wdata,
    input  wire                logic              re,
    input  wire                logic [ADDR_W-1:0] raddr,
    output vgb_pkg::pix_t                         rdata
);

    vgb_pkg::pix_t mem [DEPTH];
    vgb_pkg::pix_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/vgb_lane.sv =====
// One blur lane: computes the column filter for one output row offset.
// Tap select and symmetric pre-add, multiply, then sum and saturate.
// Depends on vgb_pkg.
`default_nettype none

module vgb_lane #(
    parameter int RADIUS = 5,
    parameter int LANE   = 0,
    parameter int IDX_W  = 4
) (
    input  wire logic                                           clk,
    input  wire vgb_pkg::pix_t [2*RADIUS:0]                     taps,
    input  wire logic [IDX_W-1:0]                               near_rows,
    input  wire logic [vgb_pkg::WC_W-1:0]                       weight_center,
    input  wire logic [vgb_pkg::NUM_OFF-1:0][vgb_pkg::WO_W-1:0] weight_off,
    input  wire logic                                           ld_sum,
    input  wire logic                                           ld_prod,
    output vgb_pkg::pix_t                                       result
);

    localparam int NC = vgb_pkg::NUM_CH;
    localparam int PW = vgb_pkg::PIX_W;

    logic [NC-1:0][PW:0]                 pair_next [RADIUS+1];
    logic [NC-1:0][PW:0]                 pair_reg  [RADIUS+1];
    logic [NC-1:0][vgb_pkg::PROD_W-1:0]  prod_next [RADIUS+1];
    logic [NC-1:0][vgb_pkg::PROD_W-1:0]  prod_reg  [RADIUS+1];
    logic [NC-1:0][vgb_pkg::ACC_W-1:0]   acc;
    logic [NC-1:0][PW-1:0]               upper_px;
    logic [NC-1:0][PW-1:0]               lower_px;
    logic [NC-1:0][PW-1:0]               sat_px;

    // Age index of a tap u rows back from the newest row, clamped to the
    // frame top (lim) and to the newest row.
    function automatic logic [IDX_W-1:0] tap_at(input int u, input logic [IDX_W-1:0] lim);
        logic [IDX_W-1:0] idx;
        if (u <= 0)
            idx = '0;
        else if (u > int'(lim))
            idx = lim;
        else
            idx = IDX_W'(u);
        return idx;
    endfunction

    always_comb
    begin
        upper_px = '0;
        lower_px = '0;
        for (int d = 0; d <= RADIUS; d++)
        begin
            upper_px = taps[tap_at(RADIUS - LANE + d, near_rows)];
            lower_px = taps[tap_at(RADIUS - LANE - d, near_rows)];
            for (int c = 0; c < NC; c++)
            begin
                if (d == 0)
                    pair_next[d][c] = {1'b0, upper_px[c]};
                else
                    pair_next[d][c] = {1'b0, upper_px[c]} + {1'b0, lower_px[c]};
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            prod_next[0][c] = {16'd0, pair_reg[0][c]} * {8'd0, weight_center};
        end
        for (int d = 1; d <= RADIUS; d++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                prod_next[d][c] = {16'd0, pair_reg[d][c]} * {9'd0, weight_off[d-1]};
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            acc[c] = '0;
            for (int d = 0; d <= RADIUS; d++)
            begin
                acc[c] = acc[c] + {{(vgb_pkg::ACC_W - vgb_pkg::PROD_W){1'b0}}, prod_reg[d][c]};
            end
            // drop the fraction, clip at full scale
            if (|acc[c][vgb_pkg::ACC_W-1:vgb_pkg::FRAC_W+PW])
                sat_px[c] = '1;
            else
                sat_px[c] = acc[c][vgb_pkg::FRAC_W+PW-1:vgb_pkg::FRAC_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_sum)
        begin
            pair_reg <= pair_next;
        end
        if (ld_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    assign result = vgb_pkg::pix_t'(sat_px);

endmodule

`default_nettype wire

// ===== design/vgb_merge.sv =====
// Merge stage: takes the lane results of one pixel and sends them out one
// transaction at a time, lowest row first. Depends on vgb_pkg.
`default_nettype none

module vgb_merge #(
    parameter int NUM_LANES = 6
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [NUM_LANES-1:0]                in_mask,
    input  wire vgb_pkg::meta_t                      in_meta,
    input  wire vgb_pkg::pix_t [NUM_LANES-1:0]       in_pix,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [vgb_pkg::PIX_W-1:0]                red_out,
    output logic [vgb_pkg::PIX_W-1:0]                green_out,
    output logic [vgb_pkg::PIX_W-1:0]                blue_out,
    output logic [vgb_pkg::ROW_W-1:0]                out_row,
    output logic [vgb_pkg::OCOL_W-1:0]               out_col,
    output logic                                     run_end,
    output logic                                     frame_end
);

    localparam int LW = $clog2(NUM_LANES);

    logic [NUM_LANES-1:0]          mask_reg;
    logic [NUM_LANES-1:0]          rest;
    vgb_pkg::pix_t [NUM_LANES-1:0] pix_reg;
    vgb_pkg::meta_t                meta_reg;
    logic [LW-1:0]                 pick_idx;
    logic                          found;
    logic                          out_free;
    logic                          emit;
    logic                          take;

    logic                          out_valid_reg;
    vgb_pkg::pix_t                 out_pix_reg;
    logic [vgb_pkg::ROW_W-1:0]     out_row_reg;
    logic [vgb_pkg::OCOL_W-1:0]    out_col_reg;
    logic                          run_end_reg;
    logic                          frame_end_reg;

    always_comb
    begin
        pick_idx = '0;
        found    = 1'b0;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            if (!found && mask_reg[j])
            begin
                pick_idx = LW'(j);
                found    = 1'b1;
            end
        end
        rest           = mask_reg;
        rest[pick_idx] = 1'b0;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = (|mask_reg) && out_free;
    assign in_ready = !(|mask_reg) || (emit && !(|rest));
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                mask_reg <= in_mask;
            else if (emit)
                mask_reg <= rest;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg  <= in_pix;
            meta_reg <= in_meta;
        end
        if (emit)
        begin
            out_pix_reg   <= pix_reg[pick_idx];
            // lane j carries row (newest - radius + j)
            out_row_reg   <= meta_reg.row - vgb_pkg::ROW_W'(NUM_LANES - 1)
                             + vgb_pkg::ROW_W'(pick_idx);
            out_col_reg   <= meta_reg.col;
            run_end_reg   <= !(|rest);
            frame_end_reg <= meta_reg.last_row && meta_reg.last_col
                             && (pick_idx == LW'(NUM_LANES - 1));
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_pix_reg.red;
    assign green_out = out_pix_reg.green;
    assign blue_out  = out_pix_reg.blue;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign run_end   = run_end_reg;
    assign frame_end = frame_end_reg;

endmodule

`default_nettype wire

// ===== design/vertical_gaussian_blur.sv =====
// Vertical Gaussian blur, column pass only. Takes one RGB raster pixel per
// clock while in_ready is high; a row is produced as the pixel MAX_RADIUS
// rows below it arrives, and each pixel of the last frame row also flushes
// the pending rows above it at that column, so such a pixel gives up to
// MAX_RADIUS+1 output transactions and holds off input while the single output
// port drains them. Stages: line store read, pre-add, multiply, sum and
// saturate, output register. The line store is 2*MAX_RADIUS single-port-write
// banks of MAX_WIDTH pixels, all read at the current column when the first
// stage advances; it needs no clearing after reset. Registers must be written
// through the cfg port only while no frame is in flight; the block does not enforce it.
`default_nettype none

module vertical_gaussian_blur #(
    parameter int MAX_RADIUS = 5,
    parameter int MAX_WIDTH  = 2048
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vgb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [vgb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [vgb_pkg::PIX_W-1:0]          red_in,
    input  wire logic [vgb_pkg::PIX_W-1:0]          green_in,
    input  wire logic [vgb_pkg::PIX_W-1:0]          blue_in,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [vgb_pkg::PIX_W-1:0]               red_out,
    output logic [vgb_pkg::PIX_W-1:0]               green_out,
    output logic [vgb_pkg::PIX_W-1:0]               blue_out,
    output logic [vgb_pkg::ROW_W-1:0]               out_row,
    output logic [vgb_pkg::OCOL_W-1:0]              out_col,
    output logic                                    run_end,
    output logic                                    frame_end
);

    localparam int STORE_ROWS = 2 * MAX_RADIUS;
    localparam int TAPS       = STORE_ROWS + 1;
    localparam int NL         = MAX_RADIUS + 1;
    localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int IDX_W      = $clog2(TAPS);

    // configuration
    logic [vgb_pkg::WC_W-1:0]                       weight_center_reg;
    logic [vgb_pkg::NUM_OFF-1:0][vgb_pkg::WO_W-1:0] weight_off_reg;
    logic [vgb_pkg::FW_W-1:0]                       frame_width_reg;
    logic [vgb_pkg::FH_W-1:0]                       frame_height_reg;

    // raster position
    logic [CW-1:0]             column_count_reg;
    logic [vgb_pkg::ROW_W-1:0] row_count_reg;
    logic [SLOT_W-1:0]         slot_reg;

    // input decode
    logic [CW-1:0]             width_last;
    logic [vgb_pkg::FH_W-1:0]  height_last;
    logic [CW-1:0]             cur_col;
    logic                      last_col;
    logic                      last_row;
    logic [IDX_W-1:0]          near_rows;
    logic [NL-1:0]             in_mask;
    vgb_pkg::meta_t            in_meta;
    vgb_pkg::pix_t             in_pix;
    logic                      accept;

    // pipeline
    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [NL-1:0]             s1_mask_reg, s2_mask_reg, s3_mask_reg;
    vgb_pkg::meta_t            s1_meta_reg, s2_meta_reg, s3_meta_reg;
    vgb_pkg::pix_t             s1_pix_reg;
    logic [SLOT_W-1:0]         s1_slot_reg;
    logic [IDX_W-1:0]          s1_near_reg;
    logic                      s1_ready, s2_ready, s3_ready, merge_ready;

    vgb_pkg::pix_t [STORE_ROWS-1:0] bank_rd;
    vgb_pkg::pix_t [TAPS-1:0]       aged;
    logic [SLOT_W-1:0]              bank_sel;
    vgb_pkg::pix_t [NL-1:0]         lane_pix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_center_reg <= vgb_pkg::WEIGHT_CENTER_RST;
            weight_off_reg    <= {vgb_pkg::NUM_OFF{vgb_pkg::WEIGHT_OFF_RST}};
            frame_width_reg   <= vgb_pkg::FRAME_WIDTH_RST;
            frame_height_reg  <= vgb_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (vgb_pkg::reg_idx_t'(cfg_index))
                vgb_pkg::REG_WEIGHT_CENTER: weight_center_reg <= cfg_data;
                vgb_pkg::REG_WEIGHT_OFF1:   weight_off_reg[0] <= cfg_data[vgb_pkg::WO_W-1:0];
                vgb_pkg::REG_WEIGHT_OFF2:   weight_off_reg[1] <= cfg_data[vgb_pkg::WO_W-1:0];
                vgb_pkg::REG_WEIGHT_OFF3:   weight_off_reg[2] <= cfg_data[vgb_pkg::WO_W-1:0];
                vgb_pkg::REG_WEIGHT_OFF4:   weight_off_reg[3] <= cfg_data[vgb_pkg::WO_W-1:0];
                vgb_pkg::REG_WEIGHT_OFF5:   weight_off_reg[4] <= cfg_data[vgb_pkg::WO_W-1:0];
                vgb_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[vgb_pkg::FW_W-1:0];
                vgb_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[vgb_pkg::FH_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Clamp width and height to at least one, width to the store size, and
    // treat any count at or past the end as the last column or row.
    always_comb
    begin
        if (frame_width_reg == '0)
            width_last = '0;
        else if (frame_width_reg > MAX_WIDTH)
            width_last = CW'(MAX_WIDTH - 1);
        else
            width_last = CW'(frame_width_reg - 1'b1);

        if (frame_height_reg == '0)
            height_last = '0;
        else
            height_last = frame_height_reg - 1'b1;

        cur_col  = (column_count_reg > width_last) ? width_last : column_count_reg;
        last_col = (cur_col == width_last);
        last_row = (row_count_reg >= height_last);

        if (row_count_reg > vgb_pkg::ROW_W'(STORE_ROWS))
            near_rows = IDX_W'(STORE_ROWS);
        else
            near_rows = IDX_W'(row_count_reg);

        // lane j produces row (current - radius + j)
        for (int j = 0; j < NL; j++)
        begin
            if (last_row)
                in_mask[j] = (int'(near_rows) >= MAX_RADIUS - j);
            else
                in_mask[j] = (j == 0) && (int'(near_rows) >= MAX_RADIUS);
        end

        in_meta.row      = row_count_reg;
        in_meta.col      = vgb_pkg::OCOL_W'(cur_col);
        in_meta.last_row = last_row;
        in_meta.last_col = last_col;

        in_pix.red   = red_in;
        in_pix.green = green_in;
        in_pix.blue  = blue_in;
    end

    assign merge_ready = 1'b0 | s3_ready_from_merge;
    logic s3_ready_from_merge;

    assign s3_ready = !s3_valid_reg || s3_ready_from_merge;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            slot_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_col)
                begin
                    column_count_reg <= '0;
                    if (last_row)
                    begin
                        row_count_reg <= '0;
                        slot_reg      <= '0;
                    end
                    else
                    begin
                        row_count_reg <= row_count_reg + 1'b1;
                        if (slot_reg == SLOT_W'(STORE_ROWS - 1))
                            slot_reg <= '0;
                        else
                            slot_reg <= slot_reg + 1'b1;
                    end
                end
                else
                begin
                    column_count_reg <= cur_col + 1'b1;
                end
            end

            // drop pixels that give no output right at entry
            if (s1_ready)
                s1_valid_reg <= accept && (|in_mask);
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_mask_reg <= in_mask;
            s1_meta_reg <= in_meta;
            s1_pix_reg  <= in_pix;
            s1_slot_reg <= slot_reg;
            s1_near_reg <= near_rows;
        end
        if (s2_ready)
        begin
            s2_mask_reg <= s1_mask_reg;
            s2_meta_reg <= s1_meta_reg;
        end
        if (s3_ready)
        begin
            s3_mask_reg <= s2_mask_reg;
            s3_meta_reg <= s2_meta_reg;
        end
    end

    for (genvar b = 0; b < STORE_ROWS; b++)
    begin : g_bank
        vgb_line_ram #(
            .DEPTH  (MAX_WIDTH),
            .ADDR_W (CW)
        ) u_bank (
            .clk   (clk),
            .we    (accept && (slot_reg == SLOT_W'(b))),
            .waddr (cur_col),
            .wdata (in_pix),
            .re    (s1_ready),
            .raddr (cur_col),
            .rdata (bank_rd[b])
        );
    end

    // Order the stored rows by age: entry t is the row t above the current one.
    always_comb
    begin
        bank_sel = '0;
        aged[0]  = s1_pix_reg;
        for (int t = 1; t < TAPS; t++)
        begin
            if (int'(s1_slot_reg) >= t)
                bank_sel = SLOT_W'(int'(s1_slot_reg) - t);
            else
                bank_sel = SLOT_W'(int'(s1_slot_reg) + STORE_ROWS - t);
            aged[t] = bank_rd[bank_sel];
        end
    end

    for (genvar j = 0; j < NL; j++)
    begin : g_lane
        vgb_lane #(
            .RADIUS (MAX_RADIUS),
            .LANE   (j),
            .IDX_W  (IDX_W)
        ) u_lane (
            .clk           (clk),
            .taps          (aged),
            .near_rows     (s1_near_reg),
            .weight_center (weight_center_reg),
            .weight_off    (weight_off_reg),
            .ld_sum        (s2_ready),
            .ld_prod       (s3_ready),
            .result        (lane_pix[j])
        );
    end

    vgb_merge #(
        .NUM_LANES (NL)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg && merge_ready),
        .in_ready  (s3_ready_from_merge),
        .in_mask   (s3_mask_reg),
        .in_meta   (s3_meta_reg),
        .in_pix    (lane_pix),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .out_row   (out_row),
        .out_col   (out_col),
        .run_end   (run_end),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire
